FILE: src/rbmd_pkg.sv
// Shared types and constants for the ring buffer message deframer.
package rbmd_pkg;

    // Input operation codes carried in the slave tuser bit.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // A byte with this bit set starts a message.
    localparam int unsigned OPC_BIT = 7;

    // Checksum seed: the XOR of all message bytes before the checksum starts here.
    localparam logic [7:0] SUM_SEED = 8'hFF;

    // Length code in opcode bits 6:5 that defers the length to the next byte.
    localparam logic [1:0] LEN_CODE_VAR = 2'd3;

    // Fixed lengths are LEN_BASE + 2 * code; shorter variable lengths are invalid.
    localparam logic [7:0] LEN_BASE = 8'd2;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    // Read sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_LEN,
        ST_SUM,
        ST_EMIT,
        ST_NOMSG
    } t_state;

endpackage

FILE: src/ring_buffer_message_deframer_core.sv
// Top level of the ring buffer message deframer: push and read sequencer.
//
// Channel   Direction  Ports                        Contents (lowest bit first)
// s_axis    in         tvalid, tready, tdata, tuser tdata = rx_byte, tuser = operation
// m_axis    out        tvalid, tready, tdata, tlast tdata = msg_byte, tuser = found,
//                      tuser                        tlast = last
//
// A push transaction writes the byte into the ring.
// A read transaction steps through the skipped non-opcode bytes, a length byte if any,
// a checksum pass over all len bytes and an emit pass over the first len - 1, where
// len is the message length; every step is one access of the ring's single read port.
// Stalls on m_axis add cycles only in the emit and no-message steps. The sequencer
// takes no new transaction until a read has handed its last result to the output
// register; that register lets the next transaction in while it waits on m_axis.
// Reset is synchronous and active low; it clears the pointers and the sequencer. The
// ring contents are not cleared and need no clearing pass.
module ring_buffer_message_deframer_core
    import rbmd_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_s_axis_tuser,   // [0] operation

    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] msg_byte
    output logic       o_m_axis_tuser,   // [0] found
    output logic       o_m_axis_tlast
);

    localparam int unsigned PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] LAST_IDX  = PW'(RING_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(RING_DEPTH);
    localparam logic [PW-1:0] ONE       = PW'(1);
    localparam logic [PW-1:0] TWO       = PW'(2);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == LAST_IDX) ? '0 : p + ONE;
    endfunction

    // Control state.
    t_state        r_state, n_state;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_ov, n_ov;

    // Working registers of the sequencer and the output register payload.
    logic [PW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_len, n_len;
    logic [PW-1:0] r_avail, n_avail;
    logic [7:0]    r_sum, n_sum;
    logic          r_found, n_found;
    logic [7:0]    r_byte, n_byte;
    logic          r_last, n_last;

    logic          in_acc;
    logic          push_acc;
    logic          slot_free;
    logic [7:0]    rd_data;
    logic [PW-1:0] idx_next;
    logic [PW-1:0] idx_next2;
    logic [PW-1:0] rp_next;
    logic          is_opc;
    logic [1:0]    len_code;
    logic [7:0]    fix_len;
    logic [PW:0]   avail_ext;
    logic [PW-1:0] avail;
    logic [7:0]    avail8;
    logic [7:0]    r_avail8;
    logic          sum_at_check;
    logic          emit_last;

    // The read address is the next index, so rd_data always shows the entry at r_idx.
    rbmd_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (push_acc),
        .i_wr_addr (r_wp),
        .i_wr_data (i_s_axis_tdata),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign push_acc        = in_acc & (i_s_axis_tuser == OP_PUSH);
    assign slot_free       = ~r_ov | i_m_axis_tready;

    assign idx_next  = ring_next(r_idx);
    assign idx_next2 = ring_next(idx_next);
    assign rp_next   = ring_next(r_rp);

    // Decode of the byte under the read index.
    assign is_opc   = rd_data[OPC_BIT];
    assign len_code = rd_data[6:5];
    assign fix_len  = {5'b0, len_code, 1'b0} + LEN_BASE;

    // Buffered byte count; the pointers differ whenever this is used.
    assign avail_ext = {1'b0, r_wp} - {1'b0, r_rp} + ((r_wp < r_rp) ? DEPTH_EXT : '0);
    assign avail     = avail_ext[PW-1:0];
    assign avail8    = {{(8 - PW){1'b0}}, avail};
    assign r_avail8  = {{(8 - PW){1'b0}}, r_avail};

    assign sum_at_check = (r_cnt == r_len - ONE);
    assign emit_last    = (r_cnt == r_len - TWO);

    // Next state of the read sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_s_axis_tuser == OP_READ) begin
                    n_state = (r_rp == r_wp) ? ST_NOMSG : ST_SKIP;
                end
            end
            ST_SKIP: begin
                priority if (!is_opc) begin
                    n_state = (idx_next == r_wp) ? ST_NOMSG : ST_SKIP;
                end else if (avail < TWO) begin
                    n_state = ST_NOMSG;
                end else if (len_code == LEN_CODE_VAR) begin
                    n_state = ST_LEN;
                end else if (avail8 < fix_len) begin
                    n_state = ST_NOMSG;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_LEN: begin
                priority if (r_avail8 < rd_data) begin
                    n_state = ST_NOMSG;
                end else if (rd_data < MIN_LEN) begin
                    n_state = ST_NOMSG;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_at_check) begin
                    n_state = (r_sum == rd_data) ? ST_EMIT : ST_NOMSG;
                end
            end
            ST_EMIT: begin
                if (slot_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_NOMSG: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Pointers, working registers and output register loads.
    always_comb begin
        n_rp    = r_rp;
        n_wp    = r_wp;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_avail = r_avail;
        n_sum   = r_sum;
        n_found = r_found;
        n_byte  = r_byte;
        n_last  = r_last;
        n_ov    = r_ov & ~i_m_axis_tready;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = r_rp;
                if (push_acc) begin
                    n_wp = ring_next(r_wp);
                end
            end
            ST_SKIP: begin
                if (!is_opc) begin
                    // Skipped bytes stay consumed even when no message follows.
                    n_rp  = idx_next;
                    n_idx = idx_next;
                end else begin
                    n_avail = avail;
                    n_sum   = SUM_SEED;
                    n_cnt   = '0;
                    n_len   = fix_len[PW-1:0];
                    if (len_code == LEN_CODE_VAR) begin
                        n_idx = idx_next;
                    end
                end
            end
            ST_LEN: begin
                n_len = rd_data[PW-1:0];
                n_idx = r_rp;
                // A too-short length counts as a bad message: drop the opcode.
                if (!(r_avail8 < rd_data) && rd_data < MIN_LEN) begin
                    n_rp = rp_next;
                end
            end
            ST_SUM: begin
                if (sum_at_check) begin
                    if (r_sum == rd_data) begin
                        n_idx = r_rp;
                        n_cnt = '0;
                    end else begin
                        n_rp = rp_next;
                    end
                end else begin
                    n_sum = r_sum ^ rd_data;
                    n_idx = idx_next;
                    n_cnt = r_cnt + ONE;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_found = 1'b1;
                    n_byte  = rd_data;
                    n_last  = emit_last;
                    if (emit_last) begin
                        // Step over the checksum byte as well.
                        n_rp = idx_next2;
                    end else begin
                        n_idx = idx_next;
                        n_cnt = r_cnt + ONE;
                    end
                end
            end
            ST_NOMSG: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_found = 1'b0;
                    n_byte  = '0;
                    n_last  = 1'b1;
                end
            end
            default: begin
                n_idx = r_rp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rp    <= '0;
            r_wp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_len   <= n_len;
        r_avail <= n_avail;
        r_sum   <= n_sum;
        r_found <= n_found;
        r_byte  <= n_byte;
        r_last  <= n_last;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_byte;
    assign o_m_axis_tuser  = r_found;
    assign o_m_axis_tlast  = r_last;

`ifndef SYNTH
    // A no-message result is always the only, and therefore last, result of a read.
    a_nomsg_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_found) |-> r_last)
        else $error("no-message result without last mark");

    // The write pointer only moves while the sequencer is idle.
    a_wp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_wp))
        else $error("write pointer moved during a read");

    // Both pointers stay inside the ring.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rp <= LAST_IDX) && (r_wp <= LAST_IDX))
        else $error("ring pointer out of range");

    // The byte counter never runs past the message length.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_EMIT) |-> (r_cnt < r_len))
        else $error("byte counter beyond message length");
`endif

endmodule

FILE: src/rbmd_ring.sv
// Byte ring storage: one write port and one read port with registered read data.
module rbmd_ring #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read port runs every cycle; the address is the next read index.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: verif/ring_buffer_message_deframer_core_tb.sv
// Self-checking testbench for the ring buffer message deframer core.
`timescale 1ns / 100ps

module ring_buffer_message_deframer_core_tb;
    import rbmd_pkg::*;

    localparam int unsigned RING_DEPTH     = 32;
    localparam int unsigned PTR_W          = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam int unsigned DIRECTED_ITEMS = 26;
    localparam int unsigned RANDOM_ITEMS   = 204;
    localparam int unsigned TAIL_ITEMS     = 40;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned STALL_LIMIT    = 2000;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_line_item;

    typedef struct packed {
        logic       found;
        logic [7:0] msg_byte;
        logic       last;
    } t_deframe_result;

    logic       i_clk;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = OP_PUSH;
    logic       s_tready;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Stimulus waiting for the driver and results waiting for the monitor.
    t_line_item      line_queue[$];
    t_deframe_result result_expect[$];

    // Predicted ring contents and pointers.
    logic [7:0]       ring_mem[RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr = '0;
    logic [PTR_W-1:0] wr_ptr = '0;

    int unsigned gen_count   = 0;
    int unsigned sent_count  = 0;
    int unsigned fault_count = 0;
    int unsigned src_gap     = 0;
    int unsigned sink_gap    = 0;
    logic        steady_tail = 1'b0;

    ring_buffer_message_deframer_core #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void expect_no_message();
        t_deframe_result res;
        res.found    = 1'b0;
        res.msg_byte = 8'h00;
        res.last     = 1'b1;
        result_expect.push_back(res);
    endfunction

    // Updates the predicted ring for one accepted transaction and queues the results.
    function automatic void deframe_step(logic op, logic [7:0] rx);
        logic [PTR_W-1:0] p;
        logic [PTR_W-1:0] fill;
        int unsigned      msg_len;
        logic [7:0]       chk;
        t_deframe_result  res;
        if (op == OP_PUSH) begin
            ring_mem[wr_ptr] = rx;
            wr_ptr = wr_ptr + PTR_ONE;
            return;
        end
        // Bytes in front of the next opcode are thrown away for good.
        while (rd_ptr != wr_ptr && !ring_mem[rd_ptr][OPC_BIT])
            rd_ptr = rd_ptr + PTR_ONE;
        fill = wr_ptr - rd_ptr;
        if (fill < 2) begin
            expect_no_message();
            return;
        end
        p = rd_ptr + PTR_ONE;
        if (ring_mem[rd_ptr][6:5] == LEN_CODE_VAR)
            msg_len = 32'(ring_mem[p]);
        else
            msg_len = LEN_BASE + 2 * ring_mem[rd_ptr][6:5];
        // An incomplete message stays in the ring untouched.
        if (fill < msg_len) begin
            expect_no_message();
            return;
        end
        if (msg_len < MIN_LEN) begin
            rd_ptr = rd_ptr + PTR_ONE;
            expect_no_message();
            return;
        end
        p   = rd_ptr;
        chk = SUM_SEED;
        for (int j = 0; j + 1 < msg_len; j++) begin
            chk = chk ^ ring_mem[p];
            p   = p + PTR_ONE;
        end
        if (chk != ring_mem[p]) begin
            rd_ptr = rd_ptr + PTR_ONE;
            expect_no_message();
            return;
        end
        p = rd_ptr;
        for (int j = 0; j + 1 < msg_len; j++) begin
            res.found    = 1'b1;
            res.msg_byte = ring_mem[p];
            res.last     = (j + 2 == msg_len);
            result_expect.push_back(res);
            p = p + PTR_ONE;
        end
        rd_ptr = p + PTR_ONE;
    endfunction

    task automatic queue_push(logic [7:0] rx);
        t_line_item item;
        item.op      = OP_PUSH;
        item.rx_byte = rx;
        line_queue.push_back(item);
        gen_count++;
    endtask

    task automatic queue_read();
        t_line_item item;
        item.op      = OP_READ;
        item.rx_byte = 8'($urandom_range(0, 255));
        line_queue.push_back(item);
        gen_count++;
    endtask

    // Queues one framed message of msg_len bytes. A nonzero split slips a read in
    // before that byte, so the read sees the message only partly buffered.
    task automatic send_frame(int unsigned msg_len, bit var_len, bit good_sum,
                              int unsigned split);
        logic [7:0] body[$];
        logic [7:0] chk;
        logic [1:0] code;
        if (var_len) begin
            body.push_back(8'(8'hE0 | $urandom_range(0, 31)));
            body.push_back(8'(msg_len));
        end else begin
            code = 2'((msg_len - LEN_BASE) / 2);
            body.push_back(8'(8'h80 | (code << 5) | $urandom_range(0, 31)));
        end
        while (body.size() + 1 < msg_len) begin
            if ($urandom_range(0, 9) == 0)
                body.push_back(8'($urandom_range(0, 255)));
            else
                body.push_back(8'($urandom_range(0, 127)));
        end
        chk = SUM_SEED;
        foreach (body[i])
            chk = chk ^ body[i];
        if (!good_sum)
            chk = chk ^ 8'($urandom_range(1, 255));
        body.push_back(chk);
        for (int i = 0; i < body.size(); i++) begin
            if (split != 0 && i == split)
                queue_read();
            queue_push(body[i]);
        end
    endtask

    // Driver: presents the queued transactions and runs the prediction as each is taken.
    always @(posedge i_clk) begin
        t_line_item nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_step(s_tuser, s_tdata);
                sent_count++;
                // The last stretch of the run goes without idle cycles.
                steady_tail <= (sent_count + TAIL_ITEMS >= DIRECTED_ITEMS + RANDOM_ITEMS);
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (line_queue.size() != 0 && !steady_tail &&
                             $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    s_tvalid <= 1'b0;
                end else if (line_queue.size() != 0) begin
                    nxt = line_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.rx_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result side and checks every result against the oldest one
    // predicted.
    always @(posedge i_clk) begin
        t_deframe_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_expect.size() == 0) begin
                    if (fault_count < 10)
                        $display("ERROR: unexpected result found=%0b byte=%02h last=%0b",
                                 m_tuser, m_tdata, m_tlast);
                    fault_count++;
                end else begin
                    want = result_expect.pop_front();
                    if (m_tuser !== want.found || m_tdata !== want.msg_byte ||
                        m_tlast !== want.last) begin
                        if (fault_count < 10)
                            $display("ERROR: expected %0b/%02h/%0b, got %0b/%02h/%0b",
                                     want.found, want.msg_byte, want.last,
                                     m_tuser, m_tdata, m_tlast);
                        fault_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when neither side has moved a transaction for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("ring_buffer_message_deframer_core verification failed");
        $finish;
    end

    initial begin
        int unsigned      pick;
        int unsigned      n;
        int unsigned      msg_len;
        bit               var_len;
        int unsigned      split;
        logic [PTR_W-1:0] fill;

        // Read on an empty ring.
        queue_read();
        // A lone opcode is not yet a message; its checksum completes the shortest one.
        queue_push(8'h80);
        queue_read();
        queue_push(8'h7F);
        queue_read();
        // Four-byte message read while only half of it has arrived.
        send_frame(4, 1'b0, 1'b1, 2);
        queue_read();
        // Bad checksum drops the opcode; the next read skips what is left.
        send_frame(2, 1'b0, 1'b0, 0);
        queue_read();
        queue_read();
        // Variable length below two.
        queue_push(8'hE0);
        queue_push(8'h01);
        queue_read();
        queue_read();
        // Variable length of two: the length byte doubles as the checksum.
        queue_push(8'hFD);
        queue_push(8'h02);
        queue_read();
        // All-ones opcode with a three-byte variable message.
        queue_push(8'hFF);
        queue_push(8'h03);
        queue_push(8'h03);
        queue_read();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (gen_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Well-formed message, sometimes behind line noise or read too early.
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) queue_push(8'($urandom_range(0, 127)));
                var_len = ($urandom_range(0, 2) == 0);
                if (var_len)
                    msg_len = $urandom_range(3, 12);
                else
                    msg_len = LEN_BASE + 2 * $urandom_range(0, 2);
                split = ($urandom_range(0, 4) == 0) ? $urandom_range(1, msg_len - 1) : 0;
                send_frame(msg_len, var_len, 1'b1, split);
                queue_read();
            end else if (pick < 65) begin
                var_len = ($urandom_range(0, 2) == 0);
                msg_len = var_len ? $urandom_range(3, 8) : LEN_BASE + 2 * $urandom_range(0, 2);
                send_frame(msg_len, var_len, 1'b0, 0);
                queue_read();
                queue_read();
            end else if (pick < 72) begin
                queue_push(8'(8'hE0 | $urandom_range(0, 31)));
                queue_push(8'($urandom_range(0, 1)));
                queue_read();
            end else if (pick < 82) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_read();
                    else
                        queue_push(8'($urandom_range(0, 255)));
                end
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) queue_read();
            end else if (pick < 95) begin
                // Longest message: overrun the ring until it looks empty, then fill
                // it with one message of the full usable depth.
                wait (line_queue.size() == 0 && !s_tvalid);
                fill = wr_ptr - rd_ptr;
                repeat ((RING_DEPTH - fill) % RING_DEPTH)
                    queue_push(8'($urandom_range(0, 127)));
                send_frame(RING_DEPTH - 1, 1'b1, 1'b1, 0);
                queue_read();
            end else begin
                repeat ($urandom_range(RING_DEPTH, RING_DEPTH + 8))
                    queue_push(8'($urandom_range(0, 255)));
                queue_read();
                queue_read();
            end
        end

        wait (line_queue.size() == 0 && !s_tvalid);
        wait (result_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (result_expect.size() != 0) begin
            $display("ERROR: %0d results never arrived", result_expect.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("ring_buffer_message_deframer_core verification clean");
        else
            $display("ring_buffer_message_deframer_core verification failed");
        $finish;
    end

endmodule
